// ===== src/vuv_pkg.sv =====
// Shared types and constants of the vertex and UV pair indexer.
package vuv_pkg;

    // One face corner as it travels from the input port to the probe unit.
    typedef struct packed {
        logic               group_start;
        logic [15:0]        vertex_index;
        logic signed [16:0] uv_index;
    } t_corner;

    // Hash mixing constant, split into its low and high words.
    localparam logic [31:0] HASH_MUL_LO = 32'h7F4A7C15;
    localparam logic [31:0] HASH_MUL_HI = 32'h9E3779B9;
    localparam int          HASH_SHIFT  = 29;
    localparam int          HV_LSB      = 16;
    localparam int          HV_W        = 48;

    // Slot reduction for table sizes that are not a power of two: the hash is folded in
    // twelve bits at a time, each fold a reciprocal multiplication and a multiply-subtract.
    localparam int DIGIT_W   = 12;
    localparam int DIGIT_CNT = HV_W / DIGIT_W;
    localparam int CNT_W     = $clog2(DIGIT_CNT);

    // Table entry layout and result widths.
    localparam int EPOCH_W     = 8;
    localparam int KEY_W       = 33;
    localparam int OUT_INDEX_W = 12;
    localparam int UV_SIZE_W   = 17;

    // Register index decoded from the word address of the configuration port.
    localparam logic REG_UV_TABLE_SIZE = 1'b0;

    typedef enum logic [2:0] {
        FR_IDLE,
        FR_MUL_HI,
        FR_MIX,
        FR_MOD,
        FR_SUB,
        FR_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        BK_SWEEP,
        BK_IDLE,
        BK_ISSUE,
        BK_CHECK
    } t_back_state;

endpackage

// ===== src/vuv_front.sv =====
// Front end: accepts corners, hashes the pair key and hands the start slot on.
module vuv_front #(
    parameter int HASH_SLOTS = 8192,
    parameter int SLOT_W     = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_enable,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  vuv_pkg::t_corner      i_corner,
    input  logic                  i_fifo_full,
    output logic                  o_push,
    output vuv_pkg::t_corner      o_push_corner,
    output logic [SLOT_W-1:0]     o_push_slot
);
    import vuv_pkg::*;

    localparam bit SLOTS_POW2 = (HASH_SLOTS == (1 << SLOT_W));
    // Partial dividend width, reciprocal shift and rounded-up reciprocal of the table size.
    localparam int          RED_N = SLOT_W + DIGIT_W;
    localparam int          RED_S = RED_N + SLOT_W;
    localparam logic [63:0] RED_R = ((64'd1 << RED_S) + 64'(HASH_SLOTS) - 64'd1) /
                                    64'(HASH_SLOTS);

    t_front_state        r_state, n_state;
    t_corner             r_corner, n_corner;
    logic [63:0]         r_p0, n_p0;
    logic [31:0]         r_p1, n_p1;
    logic [HV_W-1:0]     r_hv, n_hv;
    logic [SLOT_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [31:0]         r_q, n_q;

    logic [31:0]         mul_a, mul_b;
    logic [63:0]         mul_p;
    logic [31:0]         mix_hi;
    logic [63:0]         mix_h, mix_x;
    logic [HV_W-1:0]     hv;
    logic [RED_N-1:0]    red_t, red_r;
    logic                accept;

    // One shared 32 by 32 multiplier, used on the accept cycle, the cycle after and
    // by the slot reduction.
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Finish the 64-bit product and apply the xor-shift mix.
    assign mix_hi = r_p0[63:32] + r_p1 + (r_corner.vertex_index[15] ? HASH_MUL_LO : 32'd0);
    assign mix_h  = {mix_hi, r_p0[31:0]};
    assign mix_x  = mix_h ^ (mix_h >> HASH_SHIFT);
    assign hv     = mix_x[HV_LSB +: HV_W];

    // Running remainder with the next twelve hash bits appended, and what is left of it
    // once the quotient times the table size is taken away.
    assign red_t = {r_rem, r_hv[HV_W-1 -: DIGIT_W]};
    assign red_r = red_t - RED_N'(mul_p);

    assign o_in_stall    = !((r_state == FR_IDLE) && i_enable);
    assign accept        = i_in_valid && !o_in_stall;
    assign o_push_corner = r_corner;

    // Next state and datapath control.
    always_comb begin
        n_state     = r_state;
        n_corner    = r_corner;
        n_p0        = r_p0;
        n_p1        = r_p1;
        n_hv        = r_hv;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_q         = r_q;
        o_push      = 1'b0;
        o_push_slot = r_rem;
        mul_a       = {r_corner.vertex_index[14:0], r_corner.uv_index};
        mul_b       = HASH_MUL_HI;
        unique case (r_state)
            FR_IDLE: begin
                mul_a = {i_corner.vertex_index[14:0], i_corner.uv_index};
                mul_b = HASH_MUL_LO;
                if (accept) begin
                    n_corner = i_corner;
                    n_p0     = mul_p;
                    n_state  = FR_MUL_HI;
                end
            end
            FR_MUL_HI: begin
                n_p1    = mul_p[31:0];
                n_state = FR_MIX;
            end
            FR_MIX: begin
                if (SLOTS_POW2) begin
                    o_push_slot = hv[SLOT_W-1:0];
                    if (!i_fifo_full) begin
                        o_push  = 1'b1;
                        n_state = FR_IDLE;
                    end else begin
                        n_rem   = hv[SLOT_W-1:0];
                        n_state = FR_PUSH;
                    end
                end else begin
                    n_hv    = hv;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = FR_MOD;
                end
            end
            FR_MOD: begin
                // Quotient of the partial dividend by the reciprocal multiplication.
                mul_a   = 32'(red_t);
                mul_b   = 32'(RED_R);
                n_q     = 32'(mul_p >> RED_S);
                n_state = FR_SUB;
            end
            FR_SUB: begin
                // Take the quotient times the table size away and move to the next bits.
                mul_a = r_q;
                mul_b = 32'(HASH_SLOTS);
                n_rem = red_r[SLOT_W-1:0];
                n_hv  = r_hv << DIGIT_W;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIGIT_CNT - 1)) begin
                    n_state = FR_PUSH;
                end else begin
                    n_state = FR_MOD;
                end
            end
            FR_PUSH: begin
                if (!i_fifo_full) begin
                    o_push  = 1'b1;
                    n_state = FR_IDLE;
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_corner <= n_corner;
        r_p0     <= n_p0;
        r_p1     <= n_p1;
        r_hv     <= n_hv;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_q      <= n_q;
    end

endmodule

// ===== src/vuv_fifo.sv =====
// Two-entry queue that decouples the hash front end from the probe unit.
module vuv_fifo #(
    parameter int W = 47
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [W-1:0]  i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [W-1:0]  o_data,
    output logic          o_empty
);
    logic [W-1:0] r_mem [2];
    logic         r_wr_ptr, r_rd_ptr;
    logic [1:0]   r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/vuv_back.sv =====
// Back end: probes the pair table, inserts new pairs and holds the result beat.
module vuv_back #(
    parameter int MAX_UNIQUE = 4096,
    parameter int HASH_SLOTS = 8192,
    parameter int SLOT_W     = 13
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [vuv_pkg::UV_SIZE_W-1:0] i_uv_table_size,
    input  logic                        i_item_valid,
    input  vuv_pkg::t_corner            i_corner,
    input  logic [SLOT_W-1:0]           i_slot,
    output logic                        o_pop,
    output logic                        o_init_done,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [vuv_pkg::OUT_INDEX_W-1:0] o_out_index,
    output logic                        o_is_new,
    output logic [15:0]                 o_fetch_vertex_index,
    output logic [15:0]                 o_fetch_uv_index,
    output logic                        o_uv_in_range,
    output logic                        o_table_full
);
    import vuv_pkg::*;

    localparam int NUM_W = (MAX_UNIQUE > 1) ? $clog2(MAX_UNIQUE) : 1;
    localparam int NXT_W = $clog2(MAX_UNIQUE + 1);
    localparam int MEM_W = EPOCH_W + KEY_W + NUM_W;

    t_back_state          r_state, n_state;
    t_corner              r_corner, n_corner;
    logic [SLOT_W-1:0]    r_pos, n_pos;
    logic [SLOT_W-1:0]    r_probes, n_probes;
    logic [SLOT_W-1:0]    r_sweep_addr, n_sweep_addr;
    logic                 r_sweep_item, n_sweep_item;
    logic [EPOCH_W-1:0]   r_epoch, n_epoch;
    logic [NXT_W-1:0]     r_next, n_next;
    logic                 r_init_done, n_init_done;
    logic                 r_out_valid, n_out_valid;

    logic [MEM_W-1:0]     r_mem [HASH_SLOTS];
    logic [MEM_W-1:0]     r_rd_data;
    logic                 rd_en, wr_en;
    logic [SLOT_W-1:0]    rd_addr, wr_addr;
    logic [MEM_W-1:0]     wr_data;

    logic [EPOCH_W-1:0]   rd_epoch;
    logic [KEY_W-1:0]     rd_key, cur_key;
    logic [NUM_W-1:0]     rd_number;
    logic                 hit_valid, found, insert, last_probe, done, in_range;
    logic                 out_free, produce;
    logic [UV_SIZE_W-1:0] uv_raw;
    logic [SLOT_W-1:0]    pos_inc;

    // Fields of the entry read in the previous cycle.
    assign rd_epoch  = r_rd_data[MEM_W-1 -: EPOCH_W];
    assign rd_key    = r_rd_data[NUM_W +: KEY_W];
    assign rd_number = r_rd_data[NUM_W-1:0];

    // Classification of the probed slot; a slot from an older epoch counts as empty.
    assign uv_raw     = $unsigned(r_corner.uv_index);
    assign cur_key    = {r_corner.vertex_index, uv_raw};
    assign hit_valid  = (rd_epoch == r_epoch);
    assign found      = hit_valid && (rd_key == cur_key);
    assign insert     = !hit_valid && (r_next < NXT_W'(MAX_UNIQUE));
    assign last_probe = (r_probes == SLOT_W'(HASH_SLOTS - 1));
    assign done       = !hit_valid || found || last_probe;
    assign in_range   = !uv_raw[UV_SIZE_W-1] && (uv_raw < i_uv_table_size);
    assign pos_inc    = (r_pos == SLOT_W'(HASH_SLOTS - 1)) ? '0 : r_pos + SLOT_W'(1);

    assign out_free    = !r_out_valid || !i_out_stall;
    assign produce     = (r_state == BK_CHECK) && done && out_free;
    assign o_init_done = r_init_done;
    assign o_out_valid = r_out_valid;

    // Sequencer for clearing sweeps, probing and insertion.
    always_comb begin
        n_state      = r_state;
        n_corner     = r_corner;
        n_pos        = r_pos;
        n_probes     = r_probes;
        n_sweep_addr = r_sweep_addr;
        n_sweep_item = r_sweep_item;
        n_epoch      = r_epoch;
        n_next       = r_next;
        n_init_done  = r_init_done;
        o_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = r_pos;
        wr_en        = 1'b0;
        wr_addr      = r_pos;
        wr_data      = {r_epoch, cur_key, NUM_W'(r_next)};
        unique case (r_state)
            BK_SWEEP: begin
                wr_en   = 1'b1;
                wr_addr = r_sweep_addr;
                wr_data = '0;
                if (r_sweep_addr == SLOT_W'(HASH_SLOTS - 1)) begin
                    n_sweep_addr = '0;
                    n_epoch      = EPOCH_W'(1);
                    n_next       = '0;
                    n_init_done  = 1'b1;
                    n_state      = r_sweep_item ? BK_ISSUE : BK_IDLE;
                end else begin
                    n_sweep_addr = r_sweep_addr + SLOT_W'(1);
                end
            end
            BK_IDLE: begin
                if (i_item_valid) begin
                    o_pop    = 1'b1;
                    n_corner = i_corner;
                    n_pos    = i_slot;
                    n_probes = '0;
                    if (i_corner.group_start && (r_epoch == '1)) begin
                        // Epoch numbers are used up: wipe the table first.
                        n_sweep_item = 1'b1;
                        n_state      = BK_SWEEP;
                    end else begin
                        if (i_corner.group_start) begin
                            n_epoch = r_epoch + EPOCH_W'(1);
                            n_next  = '0;
                        end
                        rd_en   = 1'b1;
                        rd_addr = i_slot;
                        n_state = BK_CHECK;
                    end
                end
            end
            BK_ISSUE: begin
                rd_en        = 1'b1;
                rd_addr      = r_pos;
                n_sweep_item = 1'b0;
                n_state      = BK_CHECK;
            end
            BK_CHECK: begin
                if (done) begin
                    if (out_free) begin
                        if (insert) begin
                            wr_en  = 1'b1;
                            n_next = r_next + NXT_W'(1);
                        end
                        n_state = BK_IDLE;
                    end
                end else begin
                    n_pos    = pos_inc;
                    n_probes = r_probes + SLOT_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = pos_inc;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        n_out_valid = produce || (r_out_valid && i_out_stall);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_SWEEP;
            r_sweep_addr <= '0;
            r_sweep_item <= 1'b0;
            r_epoch      <= EPOCH_W'(1);
            r_next       <= '0;
            r_init_done  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_item <= n_sweep_item;
            r_epoch      <= n_epoch;
            r_next       <= n_next;
            r_init_done  <= n_init_done;
            r_out_valid  <= n_out_valid;
        end
    end

    // Working item registers.
    always_ff @(posedge i_clk) begin
        r_corner <= n_corner;
        r_pos    <= n_pos;
        r_probes <= n_probes;
    end

    // Pair table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Result beat register.
    always_ff @(posedge i_clk) begin
        if (produce) begin
            o_out_index          <= found  ? OUT_INDEX_W'(rd_number) :
                                    insert ? OUT_INDEX_W'(r_next) : '0;
            o_is_new             <= !found;
            o_fetch_vertex_index <= found ? 16'd0 : r_corner.vertex_index;
            o_fetch_uv_index     <= (!found && in_range) ? uv_raw[15:0] : 16'd0;
            o_uv_in_range        <= !found && in_range;
            o_table_full         <= !found && !insert;
        end
    end

endmodule

// ===== src/vertex_uv_pair_dedup_indexer_core.sv =====
// Top level of the vertex and UV pair indexer: register port, front end, queue and probe unit.
// An accepted corner is hashed, queued and probed in the pair table, and its result beat is registered;
// each extra hash probe adds a table read. The front end takes no new corner until it is through the two
// passes of the shared hash multiplier and has pushed the slot; a table size that is not a power of two
// adds the slot reduction to each corner. A group start that runs out of epoch numbers (every 255th) first
// wipes the table. Reset is synchronous, active low; a clearing pass follows, with the input stalled.
module vertex_uv_pair_dedup_indexer_core #(
    parameter int MAX_UNIQUE = 4096,
    parameter int HASH_SLOTS = 8192
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_group_start,
    input  logic [15:0]                 i_vertex_index,
    input  logic signed [16:0]          i_uv_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [vuv_pkg::OUT_INDEX_W-1:0] o_out_index,
    output logic                        o_is_new,
    output logic [15:0]                 o_fetch_vertex_index,
    output logic [15:0]                 o_fetch_uv_index,
    output logic                        o_uv_in_range,
    output logic                        o_table_full
);
    import vuv_pkg::*;

    localparam int SLOT_W = $clog2(HASH_SLOTS);
    localparam int Q_W    = $bits(t_corner) + SLOT_W;

    logic [UV_SIZE_W-1:0] r_uv_table_size;
    t_corner              in_corner, push_corner, head_corner;
    logic [SLOT_W-1:0]    push_slot, head_slot;
    logic                 push, pop, q_full, q_empty, init_done;
    logic [Q_W-1:0]       head_data;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_UV_TABLE_SIZE) ? 32'(r_uv_table_size) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv_table_size <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_UV_TABLE_SIZE)) begin
            r_uv_table_size <= pwdata[UV_SIZE_W-1:0];
        end
    end

    assign in_corner = '{group_start: i_group_start, vertex_index: i_vertex_index,
                         uv_index: i_uv_index};

    vuv_front #(
        .HASH_SLOTS (HASH_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (init_done),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_corner      (in_corner),
        .i_fifo_full   (q_full),
        .o_push        (push),
        .o_push_corner (push_corner),
        .o_push_slot   (push_slot)
    );

    vuv_fifo #(
        .W (Q_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_slot, push_corner}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_data  (head_data),
        .o_empty (q_empty)
    );

    assign head_slot   = head_data[Q_W-1 -: SLOT_W];
    assign head_corner = head_data[$bits(t_corner)-1:0];

    vuv_back #(
        .MAX_UNIQUE (MAX_UNIQUE),
        .HASH_SLOTS (HASH_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_uv_table_size      (r_uv_table_size),
        .i_item_valid         (!q_empty),
        .i_corner             (head_corner),
        .i_slot               (head_slot),
        .o_pop                (pop),
        .o_init_done          (init_done),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_out_index          (o_out_index),
        .o_is_new             (o_is_new),
        .o_fetch_vertex_index (o_fetch_vertex_index),
        .o_fetch_uv_index     (o_fetch_uv_index),
        .o_uv_in_range        (o_uv_in_range),
        .o_table_full         (o_table_full)
    );

    // A corner that could not be stored is always reported as a new pair.
    a_full_is_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> o_is_new)
        else $error("table_full beat without is_new");

    // A known pair carries no fetch request.
    a_known_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_new |->
            (o_fetch_vertex_index == 16'd0) && (o_fetch_uv_index == 16'd0) && !o_uv_in_range)
        else $error("known pair beat carries fetch fields");

    // No corner is taken in while the table is being cleared after reset.
    a_stall_during_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !init_done |-> o_in_stall)
        else $error("input not stalled during clearing pass");

    // The front end never pushes into a full queue, and the back never pops an empty one.
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full) && !(pop && q_empty))
        else $error("queue overflow or underflow");

endmodule
